// ----- sv/dct2d_pkg.sv -----
// Shared types, constants and the cosine table builder for the 2D DCT block.
`timescale 1ns / 1ps
`default_nettype none

package dct2d_pkg;

  // Default sizes of the block.
  localparam int MAX_LOG_ROWS_DEF = 5;
  localparam int MAX_LOG_COLS_DEF = 5;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int COS_BITS_DEF     = 16;

  // Fixed widths of the transaction fields.
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 16;
  localparam int COEF_W   = 41;
  localparam int LOG_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS = 2'd3;

  // Register values after reset.
  localparam logic [2:0] LOG_ROWS_RST = 3'd5;
  localparam logic [2:0] LOG_COLS_RST = 3'd5;
  localparam logic [5:0] OUT_ROWS_RST = 6'd32;
  localparam logic [5:0] OUT_COLS_RST = 6'd32;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Scale factors in Q30: one, sqrt(2) and two.
  localparam logic [31:0] K_ONE   = 32'd1073741824;
  localparam logic [31:0] K_SQRT2 = 32'd1518500250;
  localparam logic [31:0] K_TWO   = 32'd2147483648;

  // Pi in Q30, for the table builder.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Largest cosine table the parameter ranges call for.
  localparam int COS_MAX_BITS = 20;
  localparam int COS_MAX_LOG  = 8;
  localparam int TAB_IDX_W    = COS_MAX_LOG + 1;

  typedef logic [COS_MAX_BITS-1:0] cos_word_t;
  typedef cos_word_t [(1 << COS_MAX_LOG):0] cos_tab_t;

  typedef struct packed {
    logic                      req_type;
    logic [INDEX_W-1:0]        sample_row;
    logic [INDEX_W-1:0]        sample_col;
    logic signed [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0]        freq_row;
    logic [INDEX_W-1:0]        freq_col;
  } dct2d_req_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic                     out_of_range;
  } dct2d_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic init;
    logic issue;
    logic absolute;
    logic mul_hi;
    logic mul_lo;
    logic add_lo;
    logic emit;
  } dct2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic oor;
    logic last;
    logic pipe_busy;
    logic out_free;
  } dct2d_sts_t;

  // Quarter-wave cosine table: cos(pi*k/2^(glog+1)) for k = 0..2^glog, built
  // from a 12-term Taylor series in Q30 and rounded to frac fractional bits.
  // The series divisors are applied by shift-and-subtract long division.
  function automatic cos_tab_t build_cos_tab(input int glog, input int frac);
    cos_tab_t          tab;
    longint unsigned   kk;
    longint unsigned   x;
    longint unsigned   t;
    longint unsigned   c;
    longint unsigned   div;
    longint unsigned   part;
    longint unsigned   quo;
    longint            sum;
    tab = '0;
    for (int k = 0; k <= (1 << glog); k++) begin
      kk  = longint'(k);
      x   = (kk * PI_Q30 + (64'd1 << glog)) >> (glog + 1);
      t   = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int i = 1; i <= 12; i++) begin
        t    = (t * x) >> 30;
        t    = (t * x) >> 30;
        div  = longint'((2 * i - 1) * (2 * i));
        part = '0;
        quo  = '0;
        for (int b = 63; b >= 0; b--) begin
          part = {part[62:0], t[b]};
          if (part >= div) begin
            part   = part - div;
            quo[b] = 1'b1;
          end
        end
        t = quo;
        if ((i & 1) != 0) begin
          sum = sum - $signed(t);
        end else begin
          sum = sum + $signed(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      c = ($unsigned(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
      if (c > (64'd1 << frac)) begin
        c = 64'd1 << frac;
      end
      tab[k] = cos_word_t'(c);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dct2d_ifs.sv -----
// Valid/ready channel interfaces for requests and results of the 2D DCT block.
`timescale 1ns / 1ps
`default_nettype none

interface dct2d_req_if;
  logic                  valid;
  logic                  ready;
  dct2d_pkg::dct2d_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dct2d_rsp_if;
  logic                  valid;
  logic                  ready;
  dct2d_pkg::dct2d_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/dct2d_truncated_coefficients_top.sv -----
// Top level of the truncated 2D DCT-II coefficient block. Load transactions
// write one signed sample into a row-by-column store and leave the block idle,
// so it is ready again on the next cycle. A query transaction names a
// frequency pair (freq_row, freq_col) and yields one result transaction: the
// unnormalized DCT-II coefficient over the H x W grid in use (H = 2^log_rows,
// W = 2^log_cols, each limited to the store size), scaled by sqrt(2) for each
// nonzero frequency, with 8 fractional bits and saturated to 41 bits. A query
// at or beyond the output size (out_rows, out_cols, each limited to the grid)
// returns a zero coefficient with out_of_range set, going from the check state
// straight to the emit state without a sweep, and then back to idle. An
// in-range query runs one multiply-accumulate per stored sample, paced by the
// single read port of the sample store; it then drains the pipeline and scales
// the sum in the absolute, high-multiply, low-multiply and add states, and
// the block takes the next transaction only after it emits the result. A query
// whose result finds the previous one still waiting holds until that result is
// taken. The result sits in an output register, so the block
// accepts new transactions while a result waits to be taken. Store entries
// are not cleared at reset; every sample inside the H x W grid must be loaded
// before it is queried. Configuration writes must only happen while no query
// is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dct2d_truncated_coefficients_top #(
  parameter int MAX_LOG_ROWS = dct2d_pkg::MAX_LOG_ROWS_DEF,
  parameter int MAX_LOG_COLS = dct2d_pkg::MAX_LOG_COLS_DEF,
  parameter int SAMPLE_BITS  = dct2d_pkg::SAMPLE_BITS_DEF,
  parameter int COS_BITS     = dct2d_pkg::COS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dct2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dct2d_pkg::CFG_DATA_W-1:0] cfg_data,
  dct2d_req_if.sink                        req,
  dct2d_rsp_if.source                      rsp
);

  // Command and status between the sequencer and the datapath.
  dct2d_pkg::dct2d_cmd_t cmd;
  dct2d_pkg::dct2d_sts_t sts;
  logic                  req_query;

  // The controller only needs to know whether an offered transaction is a query.
  assign req_query = (req.payload.req_type == dct2d_pkg::REQ_QUERY);

  // The controller accepts requests in its idle state, walks the grid during a
  // query and hands the finished result to the output register.
  dct2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_query (req_query),
    .sts       (sts),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // The datapath holds the configuration registers, the sample store, the
  // multiply-accumulate pipeline, the scaling steps and the result register.
  dct2d_dp #(
    .MAX_LOG_ROWS (MAX_LOG_ROWS),
    .MAX_LOG_COLS (MAX_LOG_COLS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COS_BITS     (COS_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_payload (req.payload),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_payload (rsp.payload),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready)
  );

endmodule

`default_nettype wire

// ----- sv/dct2d_dp.sv -----
// Datapath of the 2D DCT block: sample store, MAC pipeline, scaling and result register.
`timescale 1ns / 1ps
`default_nettype none

module dct2d_dp #(
  parameter int MAX_LOG_ROWS = dct2d_pkg::MAX_LOG_ROWS_DEF,
  parameter int MAX_LOG_COLS = dct2d_pkg::MAX_LOG_COLS_DEF,
  parameter int SAMPLE_BITS  = dct2d_pkg::SAMPLE_BITS_DEF,
  parameter int COS_BITS     = dct2d_pkg::COS_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [dct2d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dct2d_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  dct2d_pkg::dct2d_req_t                 req_payload,
  input  dct2d_pkg::dct2d_cmd_t                 cmd,
  output dct2d_pkg::dct2d_sts_t                 sts,
  output dct2d_pkg::dct2d_rsp_t                 rsp_payload,
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready
);

  localparam int LOG_W   = dct2d_pkg::LOG_W;
  localparam int IDX_W   = dct2d_pkg::INDEX_W;
  localparam int COEF_W  = dct2d_pkg::COEF_W;
  localparam int G       = (MAX_LOG_ROWS > MAX_LOG_COLS) ? MAX_LOG_ROWS : MAX_LOG_COLS;
  localparam int GI_W    = G + 1;
  localparam int Q       = 1 << G;
  localparam int F       = COS_BITS - 1;
  localparam int PH_W    = G + 2;
  localparam int UX_W    = PH_W + IDX_W;
  localparam int AW      = MAX_LOG_ROWS + MAX_LOG_COLS;
  localparam int DEPTH   = 1 << AW;
  localparam int ROW_X_W = (MAX_LOG_ROWS > IDX_W) ? MAX_LOG_ROWS : IDX_W;
  localparam int COL_X_W = (MAX_LOG_COLS > IDX_W) ? MAX_LOG_COLS : IDX_W;
  localparam int SV_X_W  = (SAMPLE_BITS > dct2d_pkg::VALUE_W) ? SAMPLE_BITS : dct2d_pkg::VALUE_W;
  localparam int HR_W    = MAX_LOG_ROWS + 1;
  localparam int HC_W    = MAX_LOG_COLS + 1;
  localparam int CR_W    = (HR_W > 6) ? HR_W : 6;
  localparam int CC_W    = (HC_W > 6) ? HC_W : 6;
  localparam int PP_W    = 2 * COS_BITS;
  localparam int TERM_W  = SAMPLE_BITS + COS_BITS;
  localparam int ACC_W   = TERM_W + AW;
  localparam int MAGX_W  = (ACC_W > 31) ? ACC_W : 31;
  localparam int HI_W    = MAGX_W - 30;
  localparam int A_W     = (HI_W > 30) ? HI_W : 30;
  localparam int MUL_W   = A_W + 32;
  localparam int SC_W    = MUL_W + 1;
  localparam int RND_W   = SC_W + 1;

  localparam logic [PP_W-1:0]  P_HALF   = PP_W'(1) << (F - 1);
  localparam logic [SC_W-1:0]  LO_HALF  = SC_W'(1) << 29;
  localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (F - 9);
  localparam logic [RND_W-1:0] NEG_LIM  = RND_W'(1) << (COEF_W - 1);
  localparam logic [RND_W-1:0] POS_LIM  = NEG_LIM - RND_W'(1);

  localparam dct2d_pkg::cos_tab_t COS_TAB = dct2d_pkg::build_cos_tab(G, F);

  // Magnitude and sign of the cosine at phase a, in units of pi/2^(G+1).
  function automatic logic [COS_BITS:0] cos_at(input logic [PH_W-1:0] a);
    logic [1:0]  q;
    logic [G:0]  r;
    logic [G:0]  idx;
    logic        neg;
    q = a[PH_W-1 -: 2];
    r = GI_W'(a[G-1:0]);
    unique case (q)
      2'd0: begin idx = r;            neg = 1'b0; end
      2'd1: begin idx = GI_W'(Q) - r; neg = 1'b1; end
      2'd2: begin idx = r;            neg = 1'b1; end
      default: begin idx = GI_W'(Q) - r; neg = 1'b0; end
    endcase
    return {neg, COS_BITS'(COS_TAB[dct2d_pkg::TAB_IDX_W'(idx)])};
  endfunction

  // Configuration registers.
  logic [2:0] log_rows, log_cols;
  logic [5:0] out_rows, out_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_rows <= dct2d_pkg::LOG_ROWS_RST;
      log_cols <= dct2d_pkg::LOG_COLS_RST;
      out_rows <= dct2d_pkg::OUT_ROWS_RST;
      out_cols <= dct2d_pkg::OUT_COLS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dct2d_pkg::CFG_LOG_ROWS: log_rows <= cfg_data[2:0];
        dct2d_pkg::CFG_LOG_COLS: log_cols <= cfg_data[2:0];
        dct2d_pkg::CFG_OUT_ROWS: out_rows <= cfg_data;
        default:                 out_cols <= cfg_data;
      endcase
    end
  end

  // Query frequency pair.
  logic [IDX_W-1:0] u_r, v_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      u_r <= req_payload.freq_row;
      v_r <= req_payload.freq_col;
    end
  end

  // Sizes in use, limited to the store's dimensions.
  logic [LOG_W-1:0]        lr, lc, sh_r, sh_c;
  logic [HR_W-1:0]         h_rows;
  logic [HC_W-1:0]         w_cols;
  logic [MAX_LOG_ROWS-1:0] row_max;
  logic [MAX_LOG_COLS-1:0] col_max;
  logic [UX_W-1:0]         ux, vx;
  logic [PH_W-1:0]         base_r, base_c, step_r, step_c;
  logic [31:0]             k_sel;

  always_comb begin
    lr = (LOG_W'(log_rows) > LOG_W'(MAX_LOG_ROWS)) ? LOG_W'(MAX_LOG_ROWS) : LOG_W'(log_rows);
    lc = (LOG_W'(log_cols) > LOG_W'(MAX_LOG_COLS)) ? LOG_W'(MAX_LOG_COLS) : LOG_W'(log_cols);
    h_rows  = HR_W'(1) << lr;
    w_cols  = HC_W'(1) << lc;
    row_max = MAX_LOG_ROWS'(h_rows - HR_W'(1));
    col_max = MAX_LOG_COLS'(w_cols - HC_W'(1));
    sh_r    = LOG_W'(G) - lr;
    sh_c    = LOG_W'(G) - lc;
    ux      = UX_W'(u_r) << sh_r;
    vx      = UX_W'(v_r) << sh_c;
    base_r  = ux[PH_W-1:0];
    base_c  = vx[PH_W-1:0];
    step_r  = {base_r[PH_W-2:0], 1'b0};
    step_c  = {base_c[PH_W-2:0], 1'b0};
    if (u_r != '0 && v_r != '0) begin
      k_sel = dct2d_pkg::K_TWO;
    end else if (u_r != '0 || v_r != '0) begin
      k_sel = dct2d_pkg::K_SQRT2;
    end else begin
      k_sel = dct2d_pkg::K_ONE;
    end
  end

  // Sweep counters and cosine phases.
  logic [MAX_LOG_ROWS-1:0] n;
  logic [MAX_LOG_COLS-1:0] m;
  logic [PH_W-1:0]         ph_r, ph_c;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      n    <= '0;
      m    <= '0;
      ph_r <= base_r;
      ph_c <= base_c;
    end else if (cmd.issue) begin
      if (m == col_max) begin
        m    <= '0;
        n    <= n + 1'b1;
        ph_c <= base_c;
        ph_r <= ph_r + step_r;
      end else begin
        m    <= m + 1'b1;
        ph_c <= ph_c + step_c;
      end
    end
  end

  // Sample store; entries are undefined until loaded.
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [ROW_X_W-1:0]     row_x;
  logic [COL_X_W-1:0]     col_x;
  logic [SV_X_W-1:0]      sv_x;
  logic [AW-1:0]          wr_addr;

  always_comb begin
    row_x   = ROW_X_W'(req_payload.sample_row);
    col_x   = COL_X_W'(req_payload.sample_col);
    sv_x    = SV_X_W'($unsigned(req_payload.sample_value));
    wr_addr = {row_x[MAX_LOG_ROWS-1:0], col_x[MAX_LOG_COLS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_addr] <= sv_x[SAMPLE_BITS-1:0];
    end
    if (cmd.issue) begin
      rd_data <= mem[{n, m}];
    end
  end

  // MAC pipeline: cosine lookup, cosine product, sample product, accumulate.
  logic                     v1, v2, v3;
  logic [COS_BITS:0]        cos_row, cos_col;
  logic [COS_BITS-1:0]      cr, cc, p;
  logic                     neg0, neg1, neg2;
  logic [PP_W-1:0]          pp;
  logic [SAMPLE_BITS-1:0]   samp1;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc, term_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    cos_row = cos_at(ph_r);
    cos_col = cos_at(ph_c);
    pp      = PP_W'(cr) * PP_W'(cc) + P_HALF;
    term_x  = ACC_W'(term);
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      cr   <= cos_row[COS_BITS-1:0];
      cc   <= cos_col[COS_BITS-1:0];
      neg0 <= cos_row[COS_BITS] ^ cos_col[COS_BITS];
    end
    p     <= COS_BITS'(pp >> F);
    samp1 <= rd_data;
    neg1  <= neg0;
    term  <= TERM_W'($signed(samp1) * $signed({1'b0, p}));
    neg2  <= neg1;
    if (cmd.init) begin
      acc <= '0;
    end else if (v3) begin
      acc <= neg2 ? acc - term_x : acc + term_x;
    end
  end

  // Scaling: magnitude times the Q30 factor, in a high and a low partial product.
  logic [ACC_W-1:0]  acc_u, acc_abs;
  logic [MAGX_W-1:0] mag;
  logic              neg_acc;
  logic [A_W-1:0]    a_op;
  logic [MUL_W-1:0]  prod;
  logic [SC_W-1:0]   scaled, lo_add;

  always_comb begin
    acc_u   = $unsigned(acc);
    acc_abs = acc[ACC_W-1] ? (~acc_u + 1'b1) : acc_u;
    a_op    = cmd.mul_hi ? A_W'(mag[MAGX_W-1:30]) : A_W'(mag[29:0]);
    lo_add  = (SC_W'(prod) + LO_HALF) >> 30;
  end

  always_ff @(posedge clk) begin
    if (cmd.absolute) begin
      neg_acc <= acc[ACC_W-1];
      mag     <= MAGX_W'(acc_abs);
    end
    if (cmd.mul_hi || cmd.mul_lo) begin
      prod <= MUL_W'(a_op) * MUL_W'(k_sel);
    end
    if (cmd.mul_lo) begin
      scaled <= SC_W'(prod);
    end else if (cmd.add_lo) begin
      scaled <= scaled + lo_add;
    end
  end

  // Rounding to 8 fractional bits and saturation.
  logic [RND_W-1:0]  rnd, sat;
  logic [COEF_W-1:0] coef_mag, coef_v;
  logic              oor;

  always_comb begin
    rnd = (RND_W'(scaled) + RND_HALF) >> (F - 8);
    if (neg_acc) begin
      sat = (rnd > NEG_LIM) ? NEG_LIM : rnd;
    end else begin
      sat = (rnd > POS_LIM) ? POS_LIM : rnd;
    end
    coef_mag = sat[COEF_W-1:0];
    coef_v   = neg_acc ? (~coef_mag + 1'b1) : coef_mag;
    oor      = (6'(u_r) >= out_rows) || (CR_W'(u_r) >= CR_W'(h_rows)) ||
               (6'(v_r) >= out_cols) || (CC_W'(v_r) >= CC_W'(w_cols));
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_payload.coefficient  <= oor ? '0 : $signed(coef_v);
      rsp_payload.out_of_range <= oor;
    end
  end

  always_comb begin
    sts.oor       = oor;
    sts.last      = (n == row_max) && (m == col_max);
    sts.pipe_busy = v1 || v2 || v3;
    sts.out_free  = !rsp_valid || rsp_ready;
  end

endmodule

`default_nettype wire

// ----- sv/dct2d_ctrl.sv -----
// Controller state machine of the 2D DCT block.
`timescale 1ns / 1ps
`default_nettype none

module dct2d_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_query,
  input  dct2d_pkg::dct2d_sts_t sts,
  output logic                  req_ready,
  output dct2d_pkg::dct2d_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_SWEEP  = 9'b000000100,
    S_DRAIN  = 9'b000001000,
    S_ABS    = 9'b000010000,
    S_MUL_HI = 9'b000100000,
    S_MUL_LO = 9'b001000000,
    S_ADD_LO = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_query) begin
            cmd.start  = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_CHECK: begin
        cmd.init   = 1'b1;
        state_next = sts.oor ? S_EMIT : S_SWEEP;
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_ABS;
        end
      end
      S_ABS: begin
        cmd.absolute = 1'b1;
        state_next   = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_ADD_LO;
      end
      S_ADD_LO: begin
        cmd.add_lo = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/dct2d_truncated_coefficients_top_tb.sv -----
// Self-checking testbench for the truncated 2D DCT-II coefficient block.
`timescale 1ns / 1ps

module dct2d_truncated_coefficients_top_tb;
  import dct2d_pkg::*;

  // Sizes of the block as built with its default parameters.
  localparam int ROWS_LOG_MAX = MAX_LOG_ROWS_DEF;
  localparam int COLS_LOG_MAX = MAX_LOG_COLS_DEF;
  localparam int GRID_LOG     = (ROWS_LOG_MAX > COLS_LOG_MAX) ? ROWS_LOG_MAX : COLS_LOG_MAX;
  localparam int QUARTER      = 1 << GRID_LOG;
  localparam int FRAC         = COS_BITS_DEF - 1;
  localparam int GRID_ROWS    = 1 << ROWS_LOG_MAX;
  localparam int GRID_COLS    = 1 << COLS_LOG_MAX;

  // Fixed-point constants of the coefficient arithmetic.
  localparam longint unsigned Q30_ONE   = 64'd1 << 30;
  localparam longint unsigned Q30_SQRT2 = 64'd1518500250;
  localparam longint unsigned PI_IN_Q30 = 64'd3373259426;
  localparam longint unsigned COEF_SAT  = 64'd1 << (COEF_W - 1);

  // Worst-case busy time of one query on the full grid, plus some margin. It is
  // used as the quiet time before a register write and at the end of the run.
  localparam int LATENCY_PAD = 1040;
  localparam int TIMEOUT_NS  = 10_000_000;

  typedef enum int {PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_e;
  typedef enum logic {ROW_REG, ROW_REQ} stim_kind_e;

  // One row of the directed stimulus: either a register write or a request
  // transaction, the latter optionally with its result typed in by hand.
  typedef struct {
    stim_kind_e              kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
    dct2d_req_t              req;
    bit                      typed;
    dct2d_rsp_t              rsp;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dct2d_req_if req_ch ();
  dct2d_rsp_if rsp_ch ();

  dct2d_truncated_coefficients_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the block state: the sample grid, which entries have been
  // loaded since reset, and the four configuration registers.
  logic signed [VALUE_W-1:0] sample_grid [GRID_ROWS][GRID_COLS];
  bit                        loaded [GRID_ROWS][GRID_COLS];
  int unsigned               cfg_log_rows = LOG_ROWS_RST;
  int unsigned               cfg_log_cols = LOG_COLS_RST;
  int unsigned               cfg_out_rows = OUT_ROWS_RST;
  int unsigned               cfg_out_cols = OUT_COLS_RST;

  // Quarter-wave cosine magnitudes with FRAC fractional bits.
  int unsigned cos_quarter [QUARTER + 1];

  dct2d_rsp_t  pending_coefs [$];
  stim_row_t   directed_rows [$];
  int          mismatches;
  int          src_gap_pct;
  int          sink_stall_pct;
  bit          dirty;
  dct2d_rsp_t  got_rsp;
  dct2d_rsp_t  want_rsp;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Build the cosine table the same way the block does: a 12-term Taylor
  // series in Q30 with truncating products, rounded half up to FRAC bits.
  initial begin
    longint unsigned x;
    longint unsigned t;
    longint unsigned c;
    longint          sum;
    for (int k = 0; k <= QUARTER; k++) begin
      x   = (longint'(k) * PI_IN_Q30 + (64'd1 << GRID_LOG)) >> (GRID_LOG + 1);
      t   = Q30_ONE;
      sum = longint'(Q30_ONE);
      for (int i = 1; i <= 12; i++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / longint'((2 * i - 1) * (2 * i));
        if ((i & 1) != 0) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      c = (longint'(sum) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      if (c > (64'd1 << FRAC)) begin
        c = 64'd1 << FRAC;
      end
      cos_quarter[k] = int'(c);
    end
  end

  // Full-wave cosine of angle*pi/2^(GRID_LOG+1): the magnitude comes from the
  // quarter-wave table, mirrored in the second and fourth quadrants, and the
  // sign is negative in the second and third.
  function automatic int unsigned cos_full_wave(input int unsigned angle, output bit neg);
    int unsigned quad;
    int unsigned rem;
    angle = angle & (4 * QUARTER - 1);
    quad  = angle >> GRID_LOG;
    rem   = angle & (QUARTER - 1);
    neg   = (quad == 1) || (quad == 2);
    if ((quad & 1) != 0) begin
      return cos_quarter[QUARTER - rem];
    end
    return cos_quarter[rem];
  endfunction

  // Expected result of a query under the current register settings.
  function automatic dct2d_rsp_t dct_coefficient(input dct2d_req_t q);
    int unsigned     lr;
    int unsigned     lc;
    int unsigned     h;
    int unsigned     w;
    int unsigned     orows;
    int unsigned     ocols;
    int unsigned     u;
    int unsigned     v;
    int unsigned     cr;
    int unsigned     cc;
    bit              nr;
    bit              nc;
    longint          acc;
    longint          term;
    longint unsigned prod;
    longint unsigned mag;
    longint unsigned scale;
    longint unsigned scaled;
    longint unsigned res;
    dct2d_rsp_t      rs;
    lr    = (cfg_log_rows > ROWS_LOG_MAX) ? ROWS_LOG_MAX : cfg_log_rows;
    lc    = (cfg_log_cols > COLS_LOG_MAX) ? COLS_LOG_MAX : cfg_log_cols;
    h     = 1 << lr;
    w     = 1 << lc;
    orows = (cfg_out_rows > h) ? h : cfg_out_rows;
    ocols = (cfg_out_cols > w) ? w : cfg_out_cols;
    u     = q.freq_row;
    v     = q.freq_col;
    rs.coefficient  = '0;
    rs.out_of_range = 1'b1;
    if (u >= orows || v >= ocols) begin
      return rs;
    end
    acc = 0;
    for (int unsigned n = 0; n < h; n++) begin
      cr = cos_full_wave((u * (2 * n + 1)) << (GRID_LOG - lr), nr);
      for (int unsigned m = 0; m < w; m++) begin
        cc   = cos_full_wave((v * (2 * m + 1)) << (GRID_LOG - lc), nc);
        // Product of the two magnitudes, rounded back to FRAC bits.
        prod = (longint'(cr) * longint'(cc) + (64'd1 << (FRAC - 1))) >> FRAC;
        term = longint'(sample_grid[n][m]) * longint'(prod);
        acc  = (nr != nc) ? acc - term : acc + term;
      end
    end
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    if (u != 0 && v != 0) begin
      scale = 2 * Q30_ONE;
    end else if (u != 0 || v != 0) begin
      scale = Q30_SQRT2;
    end else begin
      scale = Q30_ONE;
    end
    // Split the Q30 multiply so nothing overflows 64 bits, then round to
    // 8 fractional bits.
    scaled = (mag >> 30) * scale
           + (((mag & (Q30_ONE - 1)) * scale + (64'd1 << 29)) >> 30);
    res    = (scaled + (64'd1 << (FRAC - 9))) >> (FRAC - 8);
    if (acc < 0) begin
      if (res > COEF_SAT) begin
        res = COEF_SAT;
      end
      rs.coefficient = COEF_W'(-res);
    end else begin
      if (res > COEF_SAT - 1) begin
        res = COEF_SAT - 1;
      end
      rs.coefficient = COEF_W'(res);
    end
    rs.out_of_range = 1'b0;
    return rs;
  endfunction

  // Random sample value with the two extremes drawn often.
  function automatic logic [VALUE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t s;
    s.kind     = ROW_REG;
    s.reg_idx  = idx;
    s.reg_data = data;
    s.req      = '0;
    s.typed    = 1'b0;
    s.rsp      = '0;
    directed_rows.push_back(s);
  endfunction

  // For a load, a and b are the sample row and column; for a query they are
  // the frequency pair. A typed row carries its expected result.
  function automatic void add_req(input logic kind, input int a, input int b,
                                  input int value, input bit typed,
                                  input longint coef, input bit oor);
    stim_row_t s;
    s.kind         = ROW_REQ;
    s.reg_idx      = '0;
    s.reg_data     = '0;
    s.req          = '0;
    s.req.req_type = kind;
    if (kind == REQ_LOAD) begin
      s.req.sample_row   = INDEX_W'(a);
      s.req.sample_col   = INDEX_W'(b);
      s.req.sample_value = VALUE_W'(value);
    end else begin
      s.req.freq_row = INDEX_W'(a);
      s.req.freq_col = INDEX_W'(b);
    end
    s.typed              = typed;
    s.rsp.coefficient    = COEF_W'(coef);
    s.rsp.out_of_range   = oor;
    directed_rows.push_back(s);
  endfunction

  task automatic wait_drained();
    while (pending_coefs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Offer one request transaction, with random gaps ahead of it, and hold it
  // until the block takes it. The shadow state is updated at the accepting
  // edge, so every query is predicted against the loads accepted before it.
  // The task returns at that rising edge; the next action starts on the
  // following falling edge, so valid is assigned at most once per time step.
  task automatic send_request(input dct2d_req_t r, input bit typed,
                              input dct2d_rsp_t given);
    @(negedge clk);
    while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do begin
      @(posedge clk);
    end while (req_ch.ready !== 1'b1);
    dirty = 1'b1;
    if (r.req_type == REQ_LOAD) begin
      sample_grid[r.sample_row][r.sample_col] = r.sample_value;
      loaded[r.sample_row][r.sample_col]      = 1'b1;
    end else begin
      pending_coefs.push_back(typed ? given : dct_coefficient(r));
    end
  endtask

  // Register writes happen only with the block idle. The block returns to idle
  // as it emits a result, and after draining the testbench also waits out a
  // full query time.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    if (dirty) begin
      wait_drained();
      repeat (LATENCY_PAD) @(negedge clk);
      dirty = 1'b0;
    end
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_LOG_ROWS: cfg_log_rows = data[2:0];
      CFG_LOG_COLS: cfg_log_cols = data[2:0];
      CFG_OUT_ROWS: cfg_out_rows = data;
      CFG_OUT_COLS: cfg_out_cols = data;
      default: ;
    endcase
  endtask

  // One random phase: set all four registers, pick the handshake pacing,
  // load every grid entry that a query could read and has not yet been
  // loaded, then run a random mix of loads and queries. Queries mostly land
  // inside the output window; the rest use any frequency pair, which mostly
  // falls out of range. Halfway through, the sender stops until every
  // outstanding result has been taken.
  task automatic run_phase(input int lr, input int lc, input int orw, input int ocl,
                           input int n_items, input pace_e pace);
    int unsigned h;
    int unsigned w;
    int unsigned orows;
    int unsigned ocols;
    logic [63:0] rnd;
    dct2d_req_t  r;
    dct2d_rsp_t  no_rsp;
    write_reg(CFG_LOG_ROWS, CFG_DATA_W'(lr));
    write_reg(CFG_LOG_COLS, CFG_DATA_W'(lc));
    write_reg(CFG_OUT_ROWS, CFG_DATA_W'(orw));
    write_reg(CFG_OUT_COLS, CFG_DATA_W'(ocl));
    case (pace)
      PACE_SRC_GAPS: begin
        src_gap_pct    = 48;
        sink_stall_pct = 0;
      end
      PACE_SINK_STALLS: begin
        src_gap_pct    = 0;
        sink_stall_pct = 48;
      end
      PACE_BOTH: begin
        src_gap_pct    = 35;
        sink_stall_pct = 35;
      end
      default: begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
    endcase
    no_rsp = '0;
    h      = 1 << ((lr > ROWS_LOG_MAX) ? ROWS_LOG_MAX : lr);
    w      = 1 << ((lc > COLS_LOG_MAX) ? COLS_LOG_MAX : lc);
    orows  = (orw > h) ? h : orw;
    ocols  = (ocl > w) ? w : ocl;

    // With a zero-sized output window every query is out of range and reads
    // nothing, so the grid needs no filling.
    if (orows != 0 && ocols != 0) begin
      for (int unsigned n = 0; n < h; n++) begin
        for (int unsigned m = 0; m < w; m++) begin
          if (!loaded[n][m]) begin
            rnd                = {$urandom, $urandom};
            r                  = rnd[$bits(dct2d_req_t)-1:0];
            r.req_type         = REQ_LOAD;
            r.sample_row       = INDEX_W'(n);
            r.sample_col       = INDEX_W'(m);
            r.sample_value     = rand_sample();
            send_request(r, 1'b0, no_rsp);
          end
        end
      end
    end

    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait_drained();
      end
      // Fields that the request kind ignores keep random contents.
      rnd = {$urandom, $urandom};
      r   = rnd[$bits(dct2d_req_t)-1:0];
      if ($urandom_range(0, 99) < 55) begin
        r.req_type = REQ_QUERY;
        if (orows != 0 && ocols != 0 && $urandom_range(0, 3) != 0) begin
          r.freq_row = INDEX_W'($urandom_range(0, orows - 1));
          r.freq_col = INDEX_W'($urandom_range(0, ocols - 1));
        end
      end else begin
        r.req_type     = REQ_LOAD;
        r.sample_value = rand_sample();
        if ($urandom_range(0, 4) != 0) begin
          r.sample_row = INDEX_W'($urandom_range(0, h - 1));
          r.sample_col = INDEX_W'($urandom_range(0, w - 1));
        end
      end
      send_request(r, 1'b0, no_rsp);
    end
  endtask

  // The result channel stalls at random according to the current pacing.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got_rsp = rsp_ch.payload;
      if (pending_coefs.size() == 0) begin
        $error("result transaction with no query outstanding: coefficient %0d",
               $signed(got_rsp.coefficient));
        mismatches++;
      end else begin
        want_rsp = pending_coefs.pop_front();
        if (got_rsp.coefficient !== want_rsp.coefficient) begin
          $error("coefficient: expected %0d, actual %0d",
                 $signed(want_rsp.coefficient), $signed(got_rsp.coefficient));
          mismatches++;
        end
        if (got_rsp.out_of_range !== want_rsp.out_of_range) begin
          $error("out_of_range: expected %0b, actual %0b",
                 want_rsp.out_of_range, got_rsp.out_of_range);
          mismatches++;
        end
      end
    end
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    mismatches     = 0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    dirty          = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    foreach (loaded[n, m]) begin
      loaded[n][m]      = 1'b0;
      sample_grid[n][m] = '0;
    end

    // Directed part. After reset the grid in use is 32 x 32 and nothing is
    // loaded, so no query is sent until the grid is shrunk to one sample.
    add_reg(CFG_LOG_ROWS, 6'd0);
    add_reg(CFG_LOG_COLS, 6'd0);
    add_reg(CFG_OUT_ROWS, 6'd1);
    add_reg(CFG_OUT_COLS, 6'd1);
    // A single full-scale sample times a unit cosine gives the sample itself
    // with 8 fractional bits.
    add_req(REQ_LOAD, 0, 0, 32767, 1'b0, 0, 1'b0);
    add_req(REQ_QUERY, 0, 0, 0, 1'b1, 64'sd8388352, 1'b0);
    add_req(REQ_LOAD, 0, 0, -32768, 1'b0, 0, 1'b0);
    add_req(REQ_QUERY, 0, 0, 0, 1'b1, -64'sd8388608, 1'b0);
    // Queries beyond the output window give a zero coefficient and the flag.
    add_req(REQ_QUERY, 1, 0, 0, 1'b1, 0, 1'b1);
    add_req(REQ_QUERY, 0, 31, 0, 1'b1, 0, 1'b1);
    add_req(REQ_QUERY, 31, 31, 0, 1'b1, 0, 1'b1);
    // Loads at the extreme addresses, outside the grid in use.
    add_req(REQ_LOAD, 31, 31, 16'h5555, 1'b0, 0, 1'b0);
    add_req(REQ_LOAD, 31, 0, 16'haaaa, 1'b0, 0, 1'b0);
    add_req(REQ_LOAD, 0, 31, 0, 1'b0, 0, 1'b0);
    // A zero output height puts every query out of range.
    add_reg(CFG_OUT_ROWS, 6'd0);
    add_req(REQ_QUERY, 0, 0, 0, 1'b1, 0, 1'b1);
    // An output height far beyond the grid is clamped to the grid.
    add_reg(CFG_OUT_ROWS, 6'd63);
    add_req(REQ_QUERY, 0, 0, 0, 1'b0, 0, 1'b0);
    // A log size above the store saturates; a zero output width keeps every
    // query out of range, so nothing outside the loaded entries is read.
    add_reg(CFG_LOG_ROWS, 6'd7);
    add_reg(CFG_OUT_COLS, 6'd0);
    add_req(REQ_QUERY, 31, 0, 0, 1'b1, 0, 1'b1);
    add_req(REQ_QUERY, 0, 0, 0, 1'b1, 0, 1'b1);
    // A 2 x 2 grid reaches the unit scale, sqrt(2) for one nonzero
    // frequency and two for both.
    add_reg(CFG_LOG_ROWS, 6'd1);
    add_reg(CFG_LOG_COLS, 6'd1);
    add_reg(CFG_OUT_ROWS, 6'd2);
    add_reg(CFG_OUT_COLS, 6'd2);
    add_req(REQ_LOAD, 0, 0, 1000, 1'b0, 0, 1'b0);
    add_req(REQ_LOAD, 0, 1, -2000, 1'b0, 0, 1'b0);
    add_req(REQ_LOAD, 1, 0, 3000, 1'b0, 0, 1'b0);
    add_req(REQ_LOAD, 1, 1, -32768, 1'b0, 0, 1'b0);
    add_req(REQ_QUERY, 0, 0, 0, 1'b0, 0, 1'b0);
    add_req(REQ_QUERY, 1, 0, 0, 1'b0, 0, 1'b0);
    add_req(REQ_QUERY, 0, 1, 0, 1'b0, 0, 1'b0);
    add_req(REQ_QUERY, 1, 1, 0, 1'b0, 0, 1'b0);
    add_req(REQ_QUERY, 2, 1, 0, 1'b1, 0, 1'b1);
    // Width log above the store with a zero output width.
    add_reg(CFG_LOG_COLS, 6'd6);
    add_reg(CFG_OUT_COLS, 6'd0);
    add_req(REQ_QUERY, 1, 31, 0, 1'b1, 0, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end
    end

    // Random part: a sweep of grid shapes and output windows, including
    // saturating log sizes, clamped and zero output sizes, and every pacing.
    run_phase(2, 2, 4, 4, 50, PACE_FULL);
    run_phase(3, 2, 5, 63, 50, PACE_SRC_GAPS);
    run_phase(0, 5, 1, 32, 45, PACE_SINK_STALLS);
    run_phase(5, 0, 32, 1, 45, PACE_BOTH);
    run_phase(7, 1, 40, 2, 40, PACE_SRC_GAPS);
    run_phase(3, 3, 8, 8, 50, PACE_SINK_STALLS);
    run_phase(1, 7, 2, 0, 40, PACE_BOTH);
    run_phase(4, 3, 16, 3, 40, PACE_FULL);

    // Let every outstanding result come back, then watch for strays.
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (LATENCY_PAD) @(posedge clk);
    if (pending_coefs.size() != 0) begin
      $error("%0d expected results never arrived", pending_coefs.size());
    end
    if (mismatches == 0 && pending_coefs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
